FILE: src/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared definitions for the lru key/value cache
// Sizes, request codes and the control bundle sent down the cell chain.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 16;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 7;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // broadcast to every cell: update enable and the deepest slot that moves
  typedef struct packed {
    logic             upd;
    logic [IDX_W-1:0] pos;
  } cell_ctrl_t;

endpackage

FILE: src/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell: one recency slot of the cache
// Holds a key/value pair, compares it against the request key and takes its
// left neighbor's pair when the move-to-front shift reaches this slot.
// ----------------------------------------------------------------------------
module lkvc_cell
  import lkvc_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  logic [CNT_W-1:0] count,
  input  logic [KEY_W-1:0] req_key,
  input  cell_ctrl_t       ctrl,
  input  logic [KEY_W-1:0] left_key,
  input  logic [VAL_W-1:0] left_value,
  output logic [KEY_W-1:0] entry_key,
  output logic [VAL_W-1:0] entry_value,
  output logic             match
);

  logic occupied;

  assign occupied = ({1'b0, idx} < {1'b0, count});
  assign match    = occupied && (entry_key == req_key);

  always_ff @(posedge clk) begin
    if (ctrl.upd && (idx <= ctrl.pos)) begin
      entry_key   <= left_key;
      entry_value <= left_value;
    end
  end

endmodule

FILE: src/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: fully associative key/value cache, lru replacement
// A chain of slot cells ordered by recency, slot 0 most recent.
// ----------------------------------------------------------------------------
// result: registered, and valid in the cycle after the request transaction
// throughput: 1 request per cycle while the receiver takes results; the whole
//   chain compares and shifts together, and that compare, encode and shift path sets the clock
// reset: synchronous, clears the occupancy count and output valid; capacity
//   resets to 64; slot contents need no reset
module lru_key_value_cache_core
  import lkvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             req_type,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] write_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             hit,
  output logic [VAL_W-1:0] read_value
);

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;

  logic [KEY_W-1:0] keys   [ENTRIES];
  logic [VAL_W-1:0] values [ENTRIES];
  logic [KEY_W-1:0] lkeys  [ENTRIES];
  logic [VAL_W-1:0] lvalues[ENTRIES];
  logic [ENTRIES-1:0] match;

  logic             any_hit;
  logic [IDX_W-1:0] hit_pos;
  logic [VAL_W-1:0] hit_value;
  logic [CNT_W-1:0] cap_eff;
  logic             full;
  logic [CNT_W-1:0] last;
  logic [VAL_W-1:0] front_value;
  cell_ctrl_t       ctrl;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // slot chain: slot 0 loads the request key and value (hit value on a get), others take the left neighbor
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_front
      assign lkeys[i]   = key;
      assign lvalues[i] = front_value;
    end else begin : g_link
      assign lkeys[i]   = keys[i-1];
      assign lvalues[i] = values[i-1];
    end
    lkvc_cell u_cell (
      .clk         (clk),
      .idx         (IDX_W'(i)),
      .count       (count),
      .req_key     (key),
      .ctrl        (ctrl),
      .left_key    (lkeys[i]),
      .left_value  (lvalues[i]),
      .entry_key   (keys[i]),
      .entry_value (values[i]),
      .match       (match[i])
    );
  end

  // keys are unique among occupied slots, so the match vector has at most one bit set
  always_comb begin
    hit_pos   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_pos   = hit_pos | IDX_W'(i);
        hit_value = hit_value | values[i];
      end
    end
  end

  assign any_hit = |match;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(capacity) > 32'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  // insert on a full store drops everything from the capacity limit back
  assign full = (count >= cap_eff);
  assign last = full ? (cap_eff - CNT_W'(1)) : count;

  assign front_value = (req_type == REQ_GET) ? hit_value : write_value;
  assign ctrl = '{upd: accept && (any_hit || (req_type == REQ_PUT)),
                  pos: any_hit ? hit_pos : last[IDX_W-1:0]};

  always_comb begin
    count_next = count;
    if (accept && (req_type == REQ_PUT) && !any_hit) begin
      count_next = full ? cap_eff : (count + CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_W'(64);
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit        <= any_hit;
      read_value <= (any_hit && (req_type == REQ_GET)) ? hit_value : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(ENTRIES))
    else $error("occupancy count exceeds slot count");

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("key matched in more than one occupied slot");

  a_put_fills: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_type == REQ_PUT)) |=> (count != '0))
    else $error("store empty after a put");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("occupancy changed without a request transaction");

endmodule

FILE: tb/sv/lkvc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lkvc_checker: response checker for the lru key/value cache
// Tracks the capacity register and the recency-ordered slots, predicts hit and
// read value for every request transaction and compares them in order.
// ----------------------------------------------------------------------------
module lkvc_checker
  import lkvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             req_type,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] write_value,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             hit,
  input  logic [VAL_W-1:0] read_value,
  output int               fail_count,
  output int               outstanding
);

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } cache_result_t;

  logic [KEY_W-1:0] slot_key [ENTRIES];
  logic [VAL_W-1:0] slot_val [ENTRIES];
  int               held;
  logic [CAP_W-1:0] cap_reg;
  cache_result_t    expected_results [$];
  int               err_cnt = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // slot pos goes to the front, slots above it shift back by one
  function automatic void move_to_front(int pos, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    for (int i = pos; i > 0; i--) begin
      slot_key[i] = slot_key[i-1];
      slot_val[i] = slot_val[i-1];
    end
    slot_key[0] = k;
    slot_val[0] = v;
  endfunction

  function automatic cache_result_t cache_access(logic rq, logic [KEY_W-1:0] k,
                                                 logic [VAL_W-1:0] v);
    cache_result_t res;
    logic          found;
    int            pos;
    int            lim;
    int            last;
    res   = '0;
    found = 1'b0;
    pos   = 0;
    for (int i = 0; i < held; i++) begin
      if (!found && slot_key[i] == k) begin
        found = 1'b1;
        pos   = i;
      end
    end
    res.hit = found;
    if (rq == REQ_GET) begin
      if (found) begin
        res.value = slot_val[pos];
        move_to_front(pos, k, slot_val[pos]);
      end
    end else if (found) begin
      move_to_front(pos, k, v);
    end else begin
      // zero capacity acts as one, anything above the slot count saturates
      lim = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg));
      if (held >= lim) begin
        last = lim - 1;
        held = lim;
      end else begin
        last = held;
        held = held + 1;
      end
      move_to_front(last, k, v);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cache_result_t want;
    if (rst) begin
      held    = 0;
      cap_reg = CAP_RESET;
      expected_results.delete();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
      end
    end else begin
      // a result leaving now belongs to an earlier request, so compare first
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: hit=%0b read_value=%h", hit, read_value);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, hit);
            err_cnt++;
          end
          if (read_value !== want.value) begin
            $error("read_value: expected %h, got %h", want.value, read_value);
            err_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(cache_access(req_type, key, write_value));
      end
    end
    fail_count  <= err_cnt;
    outstanding <= expected_results.size();
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for lru_key_value_cache_core
// Directed hit/miss/eviction cases, then random request phases under several
// capacity settings with random stalls on both channels and one long
// receiver hold-off. Checking is done by lkvc_checker.
// ----------------------------------------------------------------------------
module tb;
  import lkvc_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 200;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_valid   = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data    = '0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic             req_type    = REQ_GET;
  logic [KEY_W-1:0] key         = '0;
  logic [VAL_W-1:0] write_value = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic             hit;
  logic [VAL_W-1:0] read_value;

  int fail_count;
  int outstanding;
  int n_sent     = 0;
  int quiet      = 0;
  bit smooth_run = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_key_value_cache_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .key         (key),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .read_value  (read_value)
  );

  lkvc_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .key         (key),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .read_value  (read_value),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  task automatic send_request(input logic rq, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    if (!smooth_run && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!smooth_run && $urandom_range(99) < 31);
    end
    in_valid    <= 1'b1;
    req_type    <= rq;
    key         <= k;
    write_value <= v;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // stop offering and wait until every result has come back
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    drain();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // keys mostly from a window sized to the capacity so hits and evictions occur
  task automatic random_phase(input logic [CAP_W-1:0] c, input int count);
    logic [KEY_W-1:0] base;
    int               eff;
    int               span;
    int               put_pct;
    logic             rq;
    logic [KEY_W-1:0] k;
    eff     = (c == 0) ? 1 : ((c > ENTRIES) ? ENTRIES : int'(c));
    base    = KEY_W'($urandom);
    span    = $urandom_range(eff / 2 + 1, 2 * eff + 4);
    put_pct = $urandom_range(30, 70);
    repeat (count) begin
      rq = ($urandom_range(99) < put_pct) ? REQ_PUT : REQ_GET;
      if ($urandom_range(9) == 0) k = KEY_W'($urandom);
      else k = base + KEY_W'($urandom_range(span - 1));
      send_request(rq, k, $urandom);
    end
  endtask

  // receiver: random back-pressure plus one long hold-off while requests keep coming
  initial begin
    bit squeezed;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (!squeezed && n_sent >= 600) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= smooth_run || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("lru_key_value_cache_core regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty store, extreme keys and values, update of a held key
    send_request(REQ_GET, 16'h0000, 32'h0);
    send_request(REQ_PUT, 16'h0000, 32'h0000_0000);
    send_request(REQ_PUT, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_GET, 16'hFFFF, 32'h0);
    send_request(REQ_GET, 16'h0000, 32'hFFFF_FFFF);
    send_request(REQ_PUT, 16'hFFFF, 32'h1234_5678);
    send_request(REQ_GET, 16'hFFFF, 32'h0);
    send_request(REQ_GET, 16'h1234, 32'h0);
    send_request(REQ_PUT, 16'h1234, 32'hA5A5_A5A5);

    // zero capacity, lowered below the held count
    set_capacity(7'd0);
    send_request(REQ_GET, 16'h0000, 32'h0);
    send_request(REQ_GET, 16'h1234, 32'h0);
    send_request(REQ_PUT, 16'h00FF, 32'h5A5A_5A5A);
    send_request(REQ_GET, 16'h0000, 32'h0);
    send_request(REQ_GET, 16'h00FF, 32'h0);
    send_request(REQ_PUT, 16'h00FF, 32'h0000_0001);
    send_request(REQ_PUT, 16'h7777, 32'h0000_0002);
    send_request(REQ_GET, 16'h00FF, 32'h0);
    send_request(REQ_GET, 16'h7777, 32'h0);

    set_capacity(7'd127);
    random_phase(7'd127, 250);
    set_capacity(7'd1);
    random_phase(7'd1, 120);
    set_capacity(7'd3);
    random_phase(7'd3, 150);
    set_capacity(7'd64);
    random_phase(7'd64, 250);
    set_capacity(7'd2);
    random_phase(7'd2, 120);
    set_capacity(7'd0);
    random_phase(7'd0, 100);
    set_capacity(7'd16);
    smooth_run = 1'b1;
    random_phase(7'd16, 200);
    smooth_run = 1'b0;
    set_capacity(7'd127);
    random_phase(7'd127, 250);
    set_capacity(7'd5);
    random_phase(7'd5, 150);
    set_capacity(7'd64);
    random_phase(7'd64, 200);

    drain();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("lru_key_value_cache_core regression: pass");
    end else begin
      $display("lru_key_value_cache_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: lru_key_value_cache_core.f
src/lkvc_pkg.sv
src/lkvc_cell.sv
src/lru_key_value_cache_core.sv
tb/sv/lkvc_checker.sv
tb/sv/tb.sv
